/* rtl/baq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// baq_pkg
// Shared types and constants of the block average ASCII quantizer.
// ---------------------------------------------------------------------------
package baq_pkg;

    localparam int PIX_W      = 8;
    localparam int CHAR_W     = 7;
    localparam int TDATA_W    = 8;
    localparam int SUB_W      = 5;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_IDX_W  = 12;
    localparam int ROWS_LIMIT = 4096;
    localparam int LEVELS     = 10;
    localparam int LVL_W      = 4;
    localparam int THR_W      = 8;

    localparam logic [SUB_W-1:0]  SUB_RST  = SUB_W'(1);
    localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(1024);
    localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_SUB_SAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

    // smallest mean that reaches each level: ceil(256 * level / 10)
    localparam logic [THR_W-1:0] LEVEL_THR [LEVELS] = '{
        8'd0, 8'd26, 8'd52, 8'd77, 8'd103, 8'd128, 8'd154, 8'd180, 8'd205, 8'd231
    };

    // darkest to lightest
    localparam logic [CHAR_W-1:0] GLYPHS [LEVELS] = '{
        7'h23, 7'h40, 7'h25, 7'h2B, 7'h2A, 7'h3D, 7'h3A, 7'h2D, 7'h2E, 7'h20
    };

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_QUANT = 4'b0100,
        ST_EMIT  = 4'b1000
    } baq_state_t;

    typedef struct packed {
        logic accept;
        logic write;
        logic q_init;
        logic q_step;
        logic load_out;
    } baq_cmd_t;

    typedef struct packed {
        logic in_area;
        logic is_last;
        logic q_done;
        logic out_free;
    } baq_sts_t;

endpackage

/* rtl/baq_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// baq_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module baq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/baq_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// baq_datapath
// Position counters, column sum store, level search and output register.
// ---------------------------------------------------------------------------
module baq_datapath #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_SUB  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [baq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [baq_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [baq_pkg::PIX_W-1:0]       s_pixel,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [baq_pkg::CHAR_W-1:0]      m_char,
    output logic                            m_row_last,
    input  baq_pkg::baq_cmd_t               cmd,
    output baq_pkg::baq_sts_t               sts
);
    import baq_pkg::*;

    localparam int SW    = $clog2(MAX_SUB + 1);
    localparam int IW    = $clog2(MAX_SUB);
    localparam int AW    = $clog2(MAX_COLS);
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int SXW   = (SW > SUB_W) ? SW : SUB_W;
    localparam int WXW   = (WW > COLS_W) ? WW : COLS_W;
    localparam int CXW   = ((WW > SW) ? WW : SW) + 2;
    localparam int RXW   = ((ROWS_W > SW) ? ROWS_W : SW) + 1;
    localparam int SUMW  = PIX_W + 2 * IW;
    localparam int AREAW = 2 * SW;
    localparam int PW    = THR_W + AREAW;

    logic [SUB_W-1:0]     sub_reg;
    logic [COLS_W-1:0]    cols_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [SXW-1:0]       sub_x;
    logic [WXW-1:0]       cols_x;
    logic [SW-1:0]        s_eff;
    logic [WW-1:0]        w_eff;
    logic [ROWS_W-1:0]    h_eff;
    logic                 restart;

    logic [AW-1:0]        col_reg, col_next;
    logic [IW-1:0]        cib_reg, cib_next;
    logic [AW-1:0]        bcol_reg, bcol_next;
    logic [AW-1:0]        bstart_reg, bstart_next;
    logic [ROW_IDX_W-1:0] row_reg, row_next;
    logic [IW-1:0]        rib_reg, rib_next;
    logic [ROW_IDX_W-1:0] band_reg, band_next;

    logic                 in_area, first_pix, last_pix, row_end;
    logic [PIX_W-1:0]     pix_reg;
    logic [AW-1:0]        addr_reg;
    logic                 first_reg, last_reg, rlast_reg;

    logic [SUMW-1:0]      ram_rdata, sum_new, sum_reg;
    logic [AREAW-1:0]     area_reg;
    logic [LVL_W-1:0]     idx_reg, level_reg;
    logic [PW-1:0]        prod;
    logic                 pass;

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 rl_reg;

    // configuration registers and clamped values
    always_comb begin
        restart = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index) inside
                CFG_SUB_SAMPLE, CFG_IMAGE_COLS, CFG_IMAGE_ROWS: restart = 1'b1;
                default:                                        restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg  <= SUB_RST;
            cols_reg <= COLS_RST;
            rows_reg <= ROWS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SUB_SAMPLE: sub_reg  <= cfg_wdata[SUB_W-1:0];
                CFG_IMAGE_COLS: cols_reg <= cfg_wdata[COLS_W-1:0];
                CFG_IMAGE_ROWS: rows_reg <= cfg_wdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    assign sub_x  = SXW'(sub_reg);
    assign cols_x = WXW'(cols_reg);
    assign s_eff  = (sub_reg == '0) ? SW'(1) :
                    (sub_x > SXW'(MAX_SUB)) ? SW'(MAX_SUB) : SW'(sub_x);
    assign w_eff  = (cols_reg == '0) ? WW'(1) :
                    (cols_x > WXW'(MAX_COLS)) ? WW'(MAX_COLS) : WW'(cols_x);
    assign h_eff  = (rows_reg == '0) ? ROWS_W'(1) :
                    (rows_reg > ROWS_W'(ROWS_LIMIT)) ? ROWS_W'(ROWS_LIMIT) : rows_reg;

    // position of the current pixel
    assign in_area   = (CXW'(bstart_reg) + CXW'(s_eff) <= CXW'(w_eff))
                    && (RXW'(band_reg) + RXW'(s_eff) <= RXW'(h_eff));
    assign first_pix = (cib_reg == '0) && (rib_reg == '0);
    assign last_pix  = (SW'(cib_reg) + SW'(1) == s_eff) && (SW'(rib_reg) + SW'(1) == s_eff);
    assign row_end   = (CXW'(bstart_reg) + CXW'(s_eff) + CXW'(s_eff) > CXW'(w_eff));

    always_comb begin
        col_next    = col_reg;
        cib_next    = cib_reg;
        bcol_next   = bcol_reg;
        bstart_next = bstart_reg;
        row_next    = row_reg;
        rib_next    = rib_reg;
        band_next   = band_reg;
        if (WW'(col_reg) + WW'(1) >= w_eff) begin
            col_next    = '0;
            cib_next    = '0;
            bcol_next   = '0;
            bstart_next = '0;
            if (ROWS_W'(row_reg) + ROWS_W'(1) >= h_eff) begin
                row_next  = '0;
                rib_next  = '0;
                band_next = '0;
            end else begin
                row_next = row_reg + ROW_IDX_W'(1);
                if (SW'(rib_reg) + SW'(1) >= s_eff) begin
                    rib_next  = '0;
                    band_next = row_reg + ROW_IDX_W'(1);
                end else begin
                    rib_next = rib_reg + IW'(1);
                end
            end
        end else begin
            col_next = col_reg + AW'(1);
            if (SW'(cib_reg) + SW'(1) >= s_eff) begin
                cib_next    = '0;
                bcol_next   = bcol_reg + AW'(1);
                bstart_next = col_reg + AW'(1);
            end else begin
                cib_next = cib_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg    <= '0;
            cib_reg    <= '0;
            bcol_reg   <= '0;
            bstart_reg <= '0;
            row_reg    <= '0;
            rib_reg    <= '0;
            band_reg   <= '0;
        end else if (cmd.accept) begin
            col_reg    <= col_next;
            cib_reg    <= cib_next;
            bcol_reg   <= bcol_next;
            bstart_reg <= bstart_next;
            row_reg    <= row_next;
            rib_reg    <= rib_next;
            band_reg   <= band_next;
        end
    end

    // per pixel payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg   <= s_pixel;
            addr_reg  <= bcol_reg;
            first_reg <= first_pix;
            last_reg  <= last_pix;
            rlast_reg <= row_end;
        end
    end

    // column sum store, read at accept, written in the following cycle
    assign sum_new = first_reg ? SUMW'(pix_reg) : ram_rdata + SUMW'(pix_reg);

    baq_ram #(
        .WIDTH (SUMW),
        .DEPTH (MAX_COLS)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (addr_reg),
        .wdata (sum_new),
        .raddr (bcol_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        area_reg <= AREAW'(s_eff) * AREAW'(s_eff);
        if (cmd.write) begin
            sum_reg <= sum_new;
        end
    end

    // level search: sum >= thr * area means mean reaches that level
    assign prod = PW'(LEVEL_THR[idx_reg]) * PW'(area_reg);
    assign pass = PW'(sum_reg) >= prod;

    always_ff @(posedge aclk) begin
        if (cmd.q_init) begin
            idx_reg   <= LVL_W'(1);
            level_reg <= '0;
        end else if (cmd.q_step && pass) begin
            idx_reg   <= idx_reg + LVL_W'(1);
            level_reg <= idx_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            char_reg <= GLYPHS[level_reg];
            rl_reg   <= rlast_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_char     = char_reg;
    assign m_row_last = rl_reg;

    assign sts.in_area  = in_area;
    assign sts.is_last  = last_reg;
    assign sts.q_done   = !pass || (idx_reg == LVL_W'(LEVELS - 1));
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule

/* rtl/baq_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// baq_ctrl
// Per pixel sequencer: accept, sum update, level search, result hand-off.
// ---------------------------------------------------------------------------
module baq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  baq_pkg::baq_sts_t sts,
    output baq_pkg::baq_cmd_t cmd
);
    import baq_pkg::*;

    baq_state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.in_area) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write = 1'b1;
                if (sts.is_last) begin
                    cmd.q_init = 1'b1;
                    state_next = ST_QUANT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_QUANT: begin
                cmd.q_step = 1'b1;
                if (sts.q_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_write_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.in_area) |=> cmd.write)
        else $error("sum update missing after accepted pixel");

    a_quant_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.write && sts.is_last) |=> cmd.q_step)
        else $error("level search missing after block end");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten");

endmodule

/* rtl/block_average_ascii_quantizer_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_average_ascii_quantizer_top
// Box filter downsampler that turns grey pixels into ASCII characters.
// ---------------------------------------------------------------------------
// Pixels enter in raster order. A pixel outside the area covered by whole
// blocks stays in IDLE; any other pixel adds a WRITE state, a read and a
// write of the column sum store. The last pixel of a block adds a level
// search, one threshold compare per cycle against thr * area, and an EMIT
// state that loads the output register once it is free. The output register
// holds a character while the next pixels come in. The sum store needs no
// clearing pass: each entry is overwritten by the first pixel of its block.
// Writing any configuration register restarts the image at its first pixel.
module block_average_ascii_quantizer_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_SUB  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [baq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [baq_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [baq_pkg::TDATA_W-1:0]   s_tdata,   // pixel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [baq_pkg::TDATA_W-1:0]   m_tdata,   // ascii_char, zero pad
    output logic                          m_tlast
);
    import baq_pkg::*;

    baq_cmd_t          cmd;
    baq_sts_t          sts;
    logic [CHAR_W-1:0] m_char;

    baq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    baq_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_SUB  (MAX_SUB)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_pixel    (s_tdata[PIX_W-1:0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_char     (m_char),
        .m_row_last (m_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign m_tdata = TDATA_W'(m_char);

endmodule
